// ===== rtl/core/signed_64_by_32_divide_assert.svh =====
// ----------------------------------------------------------------------------
// signed_64_by_32_divide_assert.svh
// assertion macros used by the divider checker
// ----------------------------------------------------------------------------
`ifndef SIGNED_64_BY_32_DIVIDE_ASSERT_SVH
`define SIGNED_64_BY_32_DIVIDE_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define SDIV_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define SDIV_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/core/sdiv64_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdiv64_pkg
// types, constants and the per-stage divide step of the 64 by 32 divider
// ----------------------------------------------------------------------------
package sdiv64_pkg;

	localparam int WORD_W         = 32;
	localparam int DEND_W         = 2 * WORD_W;
	localparam int BITS_PER_STAGE = 4;
	localparam int DIV_STAGES     = DEND_W / BITS_PER_STAGE;
	// request in, operand stage, divide stages, output register
	localparam int LATENCY        = DIV_STAGES + 2;

	localparam logic [DEND_W-1:0] POS_LIMIT = DEND_W'(64'h0000_0000_7FFF_FFFF);
	localparam logic [DEND_W-1:0] NEG_LIMIT = DEND_W'(64'h0000_0000_8000_0000);
	localparam logic [DEND_W-1:0] MIN_MAG   = DEND_W'(64'h8000_0000_0000_0000);

	// one pipeline slot: partial remainder, dividend bits still to consume
	// with quotient bits shifted in from the bottom, divisor magnitude, flags
	typedef struct packed {
		logic [WORD_W-1:0] rem;
		logic [DEND_W-1:0] work;
		logic [WORD_W-1:0] dvs;
		logic              neg;
		logic              zero;
	} stage_t;

	// BITS_PER_STAGE restoring divide steps on one slot
	function automatic stage_t div_stage(input stage_t s);
		stage_t          r;
		logic [WORD_W:0] t;
		r = s;
		for (int i = 0; i < BITS_PER_STAGE; i++) begin
			t      = {r.rem, r.work[DEND_W-1]};
			r.work = {r.work[DEND_W-2:0], 1'b0};
			if (t >= {1'b0, r.dvs}) begin
				r.rem     = WORD_W'(t - {1'b0, r.dvs});
				r.work[0] = 1'b1;
			end else begin
				r.rem = t[WORD_W-1:0];
			end
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/signed_64_by_32_divide.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_64_by_32_divide
// pipelined signed 64 by 32 divider, truncating, with overflow flag
// ----------------------------------------------------------------------------
// channel   | direction | handshake     | payload
// request   | in        | start / busy  | dividend_high, dividend_low, divisor_value
// result    | out       | done (strobe) | quotient_value, overflow_flag
//
// one request accepted every cycle; busy stays low
// result strobes once its request has passed one operand stage,
// 16 restoring stages of 4 quotient bits each and one output register
// arst_n clears all valid bits; results in flight are dropped
// the pipeline never stalls since the receiver takes every result
// ----------------------------------------------------------------------------
module signed_64_by_32_divide
	import sdiv64_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic signed [WORD_W-1:0] dividend_high,
	input  logic        [WORD_W-1:0] dividend_low,
	input  logic signed [WORD_W-1:0] divisor_value,
	output logic                     done,
	output logic signed [WORD_W-1:0] quotient_value,
	output logic                     overflow_flag
);

	stage_t            op_in;
	stage_t            op_s1;
	logic              vld_s1;
	stage_t            div_s   [DIV_STAGES];
	logic              div_vld [DIV_STAGES];
	logic [DEND_W-1:0] dend;
	logic [WORD_W-1:0] dvs_raw;
	logic [DEND_W-1:0] q_mag;
	logic              ovf_nxt;
	logic [WORD_W-1:0] q_nxt;

	assign busy = 1'b0;

	// operand magnitudes and sign of the quotient
	always_comb begin
		dend         = {unsigned'(dividend_high), dividend_low};
		dvs_raw      = unsigned'(divisor_value);
		op_in.rem    = '0;
		op_in.work   = dend[DEND_W-1] ? DEND_W'(-dend) : dend;
		op_in.dvs    = dvs_raw[WORD_W-1] ? WORD_W'(-dvs_raw) : dvs_raw;
		op_in.neg    = dend[DEND_W-1] ^ dvs_raw[WORD_W-1];
		op_in.zero   = (dvs_raw == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		op_s1 <= op_in;
	end

	// restoring divide stages
	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		stage_t src;
		logic   src_vld;

		if (g == 0) begin : g_first
			assign src     = op_s1;
			assign src_vld = vld_s1;
		end else begin : g_next
			assign src     = div_s[g-1];
			assign src_vld = div_vld[g-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld[g] <= 1'b0;
			end else begin
				div_vld[g] <= src_vld;
			end
		end

		always_ff @(posedge clk) begin
			div_s[g] <= div_stage(src);
		end
	end

	// sign fix-up, range check and special cases
	always_comb begin
		q_mag = div_s[DIV_STAGES-1].work;
		if (div_s[DIV_STAGES-1].zero) begin
			ovf_nxt = 1'b1;
			q_nxt   = '0;
		end else if (!div_s[DIV_STAGES-1].neg && q_mag == MIN_MAG) begin
			// most negative dividend over minus one
			ovf_nxt = 1'b1;
			q_nxt   = '0;
		end else if (div_s[DIV_STAGES-1].neg) begin
			ovf_nxt = (q_mag > NEG_LIMIT);
			q_nxt   = WORD_W'(-q_mag[WORD_W-1:0]);
		end else begin
			ovf_nxt = (q_mag > POS_LIMIT);
			q_nxt   = q_mag[WORD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= div_vld[DIV_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		quotient_value <= signed'(q_nxt);
		overflow_flag  <= ovf_nxt;
	end

endmodule

// ===== rtl/core/sdiv64_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdiv64_checker
// port-level checks of request to result timing, the zero divisor case and division by one
// ----------------------------------------------------------------------------
`include "signed_64_by_32_divide_assert.svh"

module sdiv64_checker
	import sdiv64_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     start,
	input logic                     busy,
	input logic signed [WORD_W-1:0] dividend_high,
	input logic        [WORD_W-1:0] dividend_low,
	input logic signed [WORD_W-1:0] divisor_value,
	input logic                     done,
	input logic signed [WORD_W-1:0] quotient_value,
	input logic                     overflow_flag
);

	// every request gives a result after the fixed latency
	`SDIV_ASSERT(a_req_to_res, clk, arst_n, (start && !busy) |-> ##LATENCY done, "request lost")

	// no result without a request at the matching edge
	`SDIV_ASSERT(a_res_from_req, clk, arst_n, done |-> $past(start && !busy, LATENCY), "spurious result")

	// zero divisor gives quotient zero and overflow
	`SDIV_ASSERT(a_zero_div, clk, arst_n, (done && $past(divisor_value == '0, LATENCY)) |-> (overflow_flag && quotient_value == '0), "zero divisor result wrong")

	// a small non-negative dividend over one comes back unchanged without overflow
	`SDIV_ASSERT(a_unit_div, clk, arst_n, (done && $past(divisor_value == 32'sd1 && dividend_high == '0 && !dividend_low[WORD_W-1], LATENCY)) |-> (!overflow_flag && quotient_value == signed'($past(dividend_low, LATENCY))), "divide by one wrong")

endmodule

bind signed_64_by_32_divide sdiv64_checker u_sdiv64_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.dividend_high  (dividend_high),
	.dividend_low   (dividend_low),
	.divisor_value  (divisor_value),
	.done           (done),
	.quotient_value (quotient_value),
	.overflow_flag  (overflow_flag)
);
